### src/aeq_pkg.sv
`default_nettype none

package aeq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int QCOUNT_W        = 5;

    localparam logic [15:0] FOOT_CODE_LOW  = 16'h00C5;
    localparam logic [15:0] FOOT_CODE_HIGH = 16'h00C8;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_PUSHED   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REPORTED = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] push_code;
        logic [15:0] push_arg;
        logic        system_ready;
        logic        alerts_suppressed;
    } t_aeq_in;

    typedef struct packed {
        logic [2:0]          status;
        logic [15:0]         reported_code;
        logic [15:0]         reported_arg;
        logic [QCOUNT_W-1:0] queue_count;
    } t_aeq_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP_RD,
        S_POP_TAKE,
        S_SCAN,
        S_SCAN_END,
        S_FINISH
    } t_aeq_state;

    typedef struct packed {
        logic       capture;
        logic       push_write;
        logic       pop_take;
        logic       scan_start;
        logic       scan_step;
        logic       unlatch;
        logic       set_status;
        logic [2:0] status;
        logic       out_load;
    } t_aeq_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       push_drop;
        logic       full;
        logic       poll_ok;
        logic       latched_nz;
        logic       ring_empty;
        logic       pop_code_nz;
        logic       scan_last;
        logic       out_busy;
    } t_aeq_sts;

endpackage

`default_nettype wire

### src/alert_event_queue.sv
`default_nettype none

// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data  (t_aeq_in)
// out       output     o_out_valid / i_out_ready  o_out_data (t_aeq_out)
// cfg       input      i_cfg_we                   i_cfg_wdata (foot alarm enable)
//
// one transaction at a time; push, refused poll, unlatched clear: S_DECODE, S_FINISH
// poll: S_POP_RD, S_POP_TAKE per entry popped; a report adds the QUEUE_DEPTH match scan
// clear with an alert latched: the QUEUE_DEPTH match scan, then the latch drops
// scans are paced by the single-read-port entry memory, one entry per cycle
// synchronous active-low reset; entries need no clearing pass
// the result register lets the next transaction be taken while a result waits

module alert_event_queue
    import aeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_we,
    input  wire logic    i_cfg_wdata,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_aeq_in i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_aeq_out     o_out_data
);

    // command and status between sequencer and datapath
    t_aeq_cmd cmd;
    t_aeq_sts sts;

    // sequencer: decode, pop loop, match scan, result hand-off
    aeq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // datapath: entry memory, ring pointers, latched alert, result register
    aeq_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_data  (i_in_data),
        .i_out_ready(i_out_ready),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

### src/aeq_ram.sv
`default_nettype none

module aeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/aeq_ctrl.sv
`default_nettype none

module aeq_ctrl
    import aeq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_aeq_sts i_sts,
    output t_aeq_cmd      o_cmd
);

    t_aeq_state r_state;
    t_aeq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_IGNORED;
                n_state          = S_FINISH;
                case (i_sts.op)
                    OP_PUSH: begin
                        if (i_sts.push_drop) begin
                            o_cmd.status = ST_IGNORED;
                        end else if (i_sts.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.status     = ST_PUSHED;
                            o_cmd.push_write = 1'b1;
                        end
                    end
                    OP_POLL: begin
                        if (i_sts.poll_ok) begin
                            n_state = S_POP_RD;
                        end
                    end
                    OP_CLEAR: begin
                        if (i_sts.latched_nz) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_IGNORED;
                    end
                endcase
            end
            S_POP_RD: begin
                if (i_sts.ring_empty) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_EMPTY;
                    n_state          = S_FINISH;
                end else begin
                    n_state = S_POP_TAKE;
                end
            end
            S_POP_TAKE: begin
                o_cmd.pop_take = 1'b1;
                if (i_sts.pop_code_nz) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_REPORTED;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_POP_RD;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                // a clear drops the latch once the last entry is checked
                o_cmd.unlatch = (i_sts.op == OP_CLEAR);
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/aeq_dp.sv
`default_nettype none

module aeq_dp
    import aeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire t_aeq_in  i_in_data,
    input  wire logic     i_out_ready,
    input  wire t_aeq_cmd i_cmd,
    output t_aeq_sts      o_sts,
    output logic          o_out_valid,
    output t_aeq_out      o_out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X = (AW+1)'(QUEUE_DEPTH);

    t_aeq_in       r_item;
    logic          r_foot_en;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_wr_ptr;
    logic [15:0]   r_lat_code;
    logic [15:0]   r_lat_arg;
    logic [AW-1:0] r_scan_idx;
    logic [AW-1:0] r_chk_idx;
    logic          r_chk_vld;
    logic [2:0]    r_status;
    logic          r_out_valid;
    t_aeq_out      r_out_data;

    logic [AW:0]   count_x;
    logic [AW-1:0] count;
    logic [31:0]   count_32;
    logic [AW-1:0] rd_ptr_inc;
    logic [AW-1:0] wr_ptr_inc;
    logic          foot_code;
    logic          erase_we;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    assign count_x    = {1'b0, r_wr_ptr} + ((r_wr_ptr < r_rd_ptr) ? DEPTH_X : '0)
                        - {1'b0, r_rd_ptr};
    assign count      = count_x[AW-1:0];
    assign count_32   = 32'(count);
    assign rd_ptr_inc = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
    assign wr_ptr_inc = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;

    assign foot_code = (r_item.push_code >= FOOT_CODE_LOW)
                    && (r_item.push_code <= FOOT_CODE_HIGH);

    // entry read in the previous cycle matches the latched alert
    assign erase_we = r_chk_vld && (ram_rdata[31:16] == r_lat_code)
                   && (ram_rdata[15:0] == r_lat_arg);

    assign ram_we    = i_cmd.push_write || erase_we;
    assign ram_waddr = i_cmd.push_write ? r_wr_ptr : r_chk_idx;
    assign ram_wdata = i_cmd.push_write ? {r_item.push_code, r_item.push_arg}
                                        : {16'h0000, ram_rdata[15:0]};
    assign ram_raddr = i_cmd.scan_step ? r_scan_idx : r_rd_ptr;

    aeq_ram #(
        .WIDTH(32),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_foot_en   <= 1'b1;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_lat_code  <= '0;
            r_lat_arg   <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_foot_en <= i_cfg_wdata;
            end
            if (i_cmd.push_write) begin
                r_wr_ptr <= wr_ptr_inc;
            end
            if (i_cmd.pop_take) begin
                r_rd_ptr   <= rd_ptr_inc;
                r_lat_code <= ram_rdata[31:16];
                r_lat_arg  <= ram_rdata[15:0];
            end
            if (i_cmd.unlatch) begin
                r_lat_code <= '0;
            end
            r_chk_vld <= i_cmd.scan_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= (r_scan_idx == LAST) ? '0 : r_scan_idx + 1'b1;
        end
        r_chk_idx <= r_scan_idx;
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_data.status        <= r_status;
            r_out_data.reported_code <= r_lat_code;
            r_out_data.reported_arg  <= r_lat_arg;
            r_out_data.queue_count   <= count_32[QCOUNT_W-1:0];
        end
    end

    always_comb begin
        o_sts.op          = r_item.operation;
        o_sts.push_drop   = (!r_foot_en && foot_code)
                         || ((r_item.push_code == r_lat_code)
                             && (r_item.push_arg == r_lat_arg));
        o_sts.full        = (count == LAST);
        o_sts.poll_ok     = r_item.system_ready && !r_item.alerts_suppressed
                         && (r_lat_code == 16'h0000);
        o_sts.latched_nz  = (r_lat_code != 16'h0000);
        o_sts.ring_empty  = (r_rd_ptr == r_wr_ptr);
        o_sts.pop_code_nz = (ram_rdata[31:16] != 16'h0000);
        o_sts.scan_last   = (r_scan_idx == LAST);
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push_write && erase_we))
        else $error("push write collides with erase write");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_write |=> (count == $past(count) + 1'b1))
        else $error("push did not grow the queue by one");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_take |-> !o_sts.ring_empty)
        else $error("pop taken from an empty queue");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_valid && !i_out_ready))
        else $error("result register overwritten before hand-off");

endmodule

`default_nettype wire
